[hdl/rss_pkg.sv]
// types and constants shared by the rectangle split block
`timescale 1ns / 1ps
package rss_pkg;

	localparam int NUM_SIDES = 4;
	localparam int COORD_W   = 16;
	localparam int SIZE_W    = 15;
	// working width for edges: origin plus size needs 17 bits, compares need a sign on top
	localparam int EDGE_W    = 18;

	typedef enum logic [1:0] {
		SIDE_LEFT   = 2'd0,
		SIDE_TOP    = 2'd1,
		SIDE_RIGHT  = 2'd2,
		SIDE_BOTTOM = 2'd3
	} side_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] bg_x;
		logic signed [COORD_W-1:0] bg_y;
		logic        [SIZE_W-1:0]  bg_width;
		logic        [SIZE_W-1:0]  bg_height;
		logic signed [COORD_W-1:0] fg_x;
		logic signed [COORD_W-1:0] fg_y;
		logic        [SIZE_W-1:0]  fg_width;
		logic        [SIZE_W-1:0]  fg_height;
	} item_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] piece_x;
		logic signed [COORD_W-1:0] piece_y;
		logic        [SIZE_W-1:0]  piece_width;
		logic        [SIZE_W-1:0]  piece_height;
		side_t                     side;
		logic                      last;
	} piece_t;

endpackage

[hdl/rss_stream_if.sv]
// valid/ready stream interface carrying one payload struct
`timescale 1ns / 1ps
interface rss_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[hdl/rss_split.sv]
// edge splits of one background rectangle by one foreground rectangle
`timescale 1ns / 1ps
module rss_split (
	input  rss_pkg::item_t                       item,
	output logic [rss_pkg::NUM_SIDES-1:0]        hit,
	output rss_pkg::piece_t [rss_pkg::NUM_SIDES-1:0] pieces
);
	import rss_pkg::*;

	logic signed [EDGE_W-1:0] bx, by, bmx, bmy;
	logic signed [EDGE_W-1:0] fx, fy, fmx, fmy;
	logic signed [EDGE_W-1:0] bx1, by1, bmx2;
	logic signed [EDGE_W-1:0] d_left, d_top, w_top, d_right, h_right, w_bot, d_bot;

	always_comb begin
		bx  = EDGE_W'(item.bg_x);
		by  = EDGE_W'(item.bg_y);
		fx  = EDGE_W'(item.fg_x);
		fy  = EDGE_W'(item.fg_y);
		bmx = bx + $signed({{(EDGE_W-SIZE_W){1'b0}}, item.bg_width});
		bmy = by + $signed({{(EDGE_W-SIZE_W){1'b0}}, item.bg_height});
		fmx = fx + $signed({{(EDGE_W-SIZE_W){1'b0}}, item.fg_width});
		fmy = fy + $signed({{(EDGE_W-SIZE_W){1'b0}}, item.fg_height});

		// the far edges of the background never move on a left or top split
		hit[SIDE_LEFT] = (fx > bx) && (fx <= bmx);
		d_left = fx - bx;
		bx1 = hit[SIDE_LEFT] ? fx : bx;

		hit[SIDE_TOP] = (fy > by) && (fy <= bmy);
		d_top = fy - by;
		w_top = bmx - bx1;
		by1 = hit[SIDE_TOP] ? fy : by;

		hit[SIDE_RIGHT] = (fmx > bx1) && (fmx <= bmx);
		d_right = bmx - fmx;
		h_right = bmy - by1;
		bmx2 = hit[SIDE_RIGHT] ? fmx : bmx;

		hit[SIDE_BOTTOM] = (fmy > by1) && (fmy <= bmy);
		d_bot = bmy - fmy;
		w_bot = bmx2 - bx1;

		pieces[SIDE_LEFT].piece_x      = item.bg_x;
		pieces[SIDE_LEFT].piece_y      = item.bg_y;
		pieces[SIDE_LEFT].piece_width  = d_left[SIZE_W-1:0];
		pieces[SIDE_LEFT].piece_height = item.bg_height;
		pieces[SIDE_LEFT].side         = SIDE_LEFT;
		pieces[SIDE_LEFT].last         = 1'b0;

		pieces[SIDE_TOP].piece_x       = bx1[COORD_W-1:0];
		pieces[SIDE_TOP].piece_y       = item.bg_y;
		pieces[SIDE_TOP].piece_width   = w_top[SIZE_W-1:0];
		pieces[SIDE_TOP].piece_height  = d_top[SIZE_W-1:0];
		pieces[SIDE_TOP].side          = SIDE_TOP;
		pieces[SIDE_TOP].last          = 1'b0;

		// right piece origin is the foreground max edge, low bits kept
		pieces[SIDE_RIGHT].piece_x      = fmx[COORD_W-1:0];
		pieces[SIDE_RIGHT].piece_y      = by1[COORD_W-1:0];
		pieces[SIDE_RIGHT].piece_width  = d_right[SIZE_W-1:0];
		pieces[SIDE_RIGHT].piece_height = h_right[SIZE_W-1:0];
		pieces[SIDE_RIGHT].side         = SIDE_RIGHT;
		pieces[SIDE_RIGHT].last         = 1'b0;

		pieces[SIDE_BOTTOM].piece_x      = bx1[COORD_W-1:0];
		pieces[SIDE_BOTTOM].piece_y      = fmy[COORD_W-1:0];
		pieces[SIDE_BOTTOM].piece_width  = w_bot[SIZE_W-1:0];
		pieces[SIDE_BOTTOM].piece_height = d_bot[SIZE_W-1:0];
		pieces[SIDE_BOTTOM].side         = SIDE_BOTTOM;
		pieces[SIDE_BOTTOM].last         = 1'b0;
	end
endmodule

[hdl/rect_subtract_split_core.sv]
// Rectangle subtraction by edge splitting. Each transfer on in_item carries a background and a
// foreground rectangle; out_item then gives zero to four pieces of the background not covered
// by the foreground, in the order left, top, right, bottom, with last set on the final one.
// Pieces of zero width or height are still given; an item with no split gives nothing. The
// item is registered, all four splits are worked out in one pass into a piece buffer, and the
// buffer drains one piece per cycle into the output register while the output is not stalled.
// An item holds the buffer until its final piece leaves, so items with one piece or none flow
// at one per cycle when nothing stalls. The first piece of an item passes the item register,
// the piece buffer and the output register before it appears on out_item.
`timescale 1ns / 1ps
module rect_subtract_split_core (
	input  logic         clk,
	input  logic         arst_n,
	rss_stream_if.sink   in_item,
	rss_stream_if.source out_item
);
	import rss_pkg::*;

	logic                          valid_s1;
	item_t                         item_s1;
	logic [NUM_SIDES-1:0]          hit;
	piece_t [NUM_SIDES-1:0]        pieces;
	piece_t [NUM_SIDES-1:0]        pc_q;
	logic [NUM_SIDES-1:0]          mask_q;
	logic [NUM_SIDES-1:0]          low_bit;
	logic [NUM_SIDES-1:0]          rest;
	logic [$clog2(NUM_SIDES)-1:0]  sel;
	logic                          out_valid_q;
	piece_t                        out_data_q;
	logic                          out_free;
	logic                          emit;
	logic                          buf_free;
	logic                          load;
	piece_t                        next_piece;

	rss_split u_split (
		.item   (item_s1),
		.hit    (hit),
		.pieces (pieces)
	);

	always_comb begin
		low_bit = mask_q & (~mask_q + NUM_SIDES'(1));
		rest    = mask_q & ~low_bit;
		priority if (mask_q[SIDE_LEFT]) begin
			sel = SIDE_LEFT;
		end else if (mask_q[SIDE_TOP]) begin
			sel = SIDE_TOP;
		end else if (mask_q[SIDE_RIGHT]) begin
			sel = SIDE_RIGHT;
		end else begin
			sel = SIDE_BOTTOM;
		end
		next_piece      = pc_q[sel];
		next_piece.last = (rest == '0);
	end

	assign out_free = !out_valid_q || out_item.ready;
	assign emit     = (mask_q != '0) && out_free;
	// buffer takes the next item as its final piece leaves
	assign buf_free = (mask_q == '0) || (emit && (rest == '0));
	assign load     = valid_s1 && buf_free;

	assign in_item.ready = !valid_s1 || buf_free;
	assign out_item.valid = out_valid_q;
	assign out_item.data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			mask_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_item.valid && in_item.ready) begin
				valid_s1 <= 1'b1;
			end else if (load) begin
				valid_s1 <= 1'b0;
			end
			if (load) begin
				mask_q <= hit;
			end else if (emit) begin
				mask_q <= rest;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_item.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_item.valid && in_item.ready) begin
			item_s1 <= in_item.data;
		end
		if (load) begin
			pc_q <= pieces;
		end
		if (emit) begin
			out_data_q <= next_piece;
		end
	end
endmodule

[hdl/rss_check.sv]
// port-level checks for the rectangle split block, bound to the top level
`timescale 1ns / 1ps
module rss_check (
	input logic             clk,
	input logic             arst_n,
	input logic             out_valid,
	input logic             out_ready,
	input rss_pkg::piece_t  out_data
);
	import rss_pkg::*;

	logic  mid_q;
	side_t prev_side_q;
	logic  out_xfer;

	assign out_xfer = out_valid && out_ready;

	// tracks whether a transfer inside one item's piece run has been seen
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_q       <= 1'b0;
			prev_side_q <= SIDE_LEFT;
		end else if (out_xfer) begin
			mid_q       <= !out_data.last;
			prev_side_q <= out_data.side;
		end
	end

	a_reset_idle: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("output valid during reset");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled piece changed or dropped");

	a_side_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && mid_q |-> out_data.side > prev_side_q)
		else $error("pieces of one item out of side order");

	a_left_width: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.side == SIDE_LEFT |-> out_data.piece_width != '0)
		else $error("left piece with zero width");

	a_top_height: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.side == SIDE_TOP |-> out_data.piece_height != '0)
		else $error("top piece with zero height");
endmodule

bind rect_subtract_split_core rss_check u_rss_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_item.valid),
	.out_ready (out_item.ready),
	.out_data  (out_item.data)
);
